FILE: hw/rtl/rpse_pkg.sv
// Shared types and constants for the Rice parameter select and encode block.
// No dependencies.
package rpse_pkg;

  localparam int ResW       = 32;
  localparam int SumW       = 48;
  localparam int NumShifts  = 31;
  localparam int CntW       = 16;
  localparam int ParamW     = 5;
  localparam int RemW       = 30;
  localparam int ProdW      = 64;
  localparam int DivW       = 49;
  localparam int DivCntW    = 6;
  localparam int CostW      = 49;

  localparam logic [CntW-1:0]    MaxPartition = 16'd65535;
  localparam logic [ResW-1:0]    Ln2Q32       = 32'd2977044472;
  localparam logic [ParamW-1:0]  MaxKNarrow   = 5'd14;
  localparam logic [ParamW-1:0]  MaxKWide     = 5'd30;

  localparam logic KindAnalysis = 1'b0;
  localparam logic KindEncode   = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [ResW-1:0] u;
    logic            last;
  } rpse_item_t;

  typedef struct packed {
    logic              kind;
    logic [ParamW-1:0] param;
    logic [ResW-1:0]   zeros;
    logic [RemW-1:0]   rem;
  } rpse_result_t;

endpackage

FILE: hw/rtl/rpse_front.sv
// Front end: accepts input items, folds the residual, queues two items.
// Depends on rpse_pkg.
module rpse_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [rpse_pkg::ResW-1:0] in_residual,
  input  logic                      in_last,
  output logic                      q_valid,
  input  logic                      q_pop,
  output rpse_pkg::rpse_item_t      q_item
);
  import rpse_pkg::*;

  rpse_item_t  mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  rpse_item_t  item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  always_comb begin
    item.kind = in_kind;
    item.u    = (in_residual << 1) ^ {ResW{in_residual[ResW-1]}};
    item.last = in_last;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: hw/rtl/rpse_back.sv
// Back end: accumulates shifted sums, picks the parameter, encodes residuals.
// Depends on rpse_pkg.
module rpse_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wide,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  rpse_pkg::rpse_item_t   q_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rpse_pkg::rpse_result_t out_result
);
  import rpse_pkg::*;

  typedef enum logic [5:0] {
    ST_RUN    = 6'b000001,
    ST_MUL_LO = 6'b000010,
    ST_MUL_HI = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_CMP    = 6'b010000,
    ST_OUT    = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [SumW-1:0]     sums_r [NumShifts];
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic [ParamW-1:0]   chosen_r, chosen_nxt;
  logic [ParamW-1:0]   maxk_r, maxk_nxt;
  logic [ProdW-1:0]    prod_r, prod_nxt;
  logic [DivW-1:0]     t_r, t_nxt;
  logic [CntW-1:0]     rem_r, rem_nxt;
  logic [DivCntW-1:0]  dcnt_r, dcnt_nxt;
  logic                found_r, found_nxt;
  logic [DivCntW-1:0]  msb_r, msb_nxt;
  logic [ParamW-1:0]   kc_r, kc_nxt;
  logic [ParamW-1:0]   hik_r, hik_nxt;
  logic [ParamW-1:0]   best_r, best_nxt;
  logic [CostW-1:0]    bestc_r, bestc_nxt;
  logic                out_valid_r, out_valid_nxt;
  rpse_result_t        out_r, out_nxt;

  logic                out_free, acc_en, clr_en;
  logic [CntW:0]       trial;
  logic [DivCntW-1:0]  est_raw;
  logic [ParamW-1:0]   est;
  logic [CostW-1:0]    cost;
  logic [ResW-1:0]     kmask;

  assign out_free   = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  always_comb begin
    q_pop = 1'b0;
    if (state_r == ST_RUN && q_valid) begin
      if (q_item.kind == KindEncode) begin
        q_pop = out_free;
      end else begin
        q_pop = 1'b1;
      end
    end
  end

  assign acc_en = q_pop && q_item.kind == KindAnalysis && cnt_r != MaxPartition;
  assign clr_en = state_r == ST_OUT && out_free;

  assign trial   = {rem_r, t_r[DivW-1]};
  assign est_raw = found_r ? msb_r : '0;
  assign est     = (est_raw > {1'b0, maxk_r}) ? maxk_r : est_raw[ParamW-1:0];
  assign cost    = {1'b0, sums_r[kc_r]}
                 + CostW'(cnt_r * ({1'b0, kc_r} + 6'd1));
  assign kmask   = (32'd1 << chosen_r) - 32'd1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    chosen_nxt    = chosen_r;
    maxk_nxt      = maxk_r;
    prod_nxt      = prod_r;
    t_nxt         = t_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    found_nxt     = found_r;
    msb_nxt       = msb_r;
    kc_nxt        = kc_r;
    hik_nxt       = hik_r;
    best_nxt      = best_r;
    bestc_nxt     = bestc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      ST_RUN: begin
        if (q_pop) begin
          if (q_item.kind == KindEncode) begin
            out_valid_nxt = 1'b1;
            out_nxt.kind  = KindEncode;
            out_nxt.param = chosen_r;
            out_nxt.zeros = q_item.u >> chosen_r;
            out_nxt.rem   = RemW'(q_item.u & kmask);
          end else begin
            if (acc_en) begin
              cnt_nxt = cnt_r + 16'd1;
            end
            if (q_item.last) begin
              maxk_nxt  = wide ? MaxKWide : MaxKNarrow;
              state_nxt = ST_MUL_LO;
            end
          end
        end
      end
      ST_MUL_LO: begin
        best_nxt = '0;
        if (sums_r[0] == '0 || cnt_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          prod_nxt  = sums_r[0][31:0] * Ln2Q32;
          state_nxt = ST_MUL_HI;
        end
      end
      ST_MUL_HI: begin
        t_nxt     = DivW'(sums_r[0][SumW-1:32] * Ln2Q32) + DivW'(prod_r[ProdW-1:32]);
        rem_nxt   = '0;
        dcnt_nxt  = DivCntW'(DivW - 1);
        found_nxt = 1'b0;
        msb_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // One quotient bit per cycle, MSB first; the first set bit is the msb.
        t_nxt = {t_r[DivW-2:0], 1'b0};
        if (trial >= {1'b0, cnt_r}) begin
          rem_nxt = CntW'(trial - {1'b0, cnt_r});
          if (!found_r) begin
            found_nxt = 1'b1;
            msb_nxt   = dcnt_r;
          end
        end else begin
          rem_nxt = trial[CntW-1:0];
        end
        if (dcnt_r == '0) begin
          state_nxt = ST_CMP;
        end else begin
          dcnt_nxt = dcnt_r - 6'd1;
        end
      end
      ST_CMP: begin
        // First cycle sets up the window around the estimate.
        if (bestc_r == '1 && kc_r == '1) begin
          kc_nxt  = (est != '0) ? est - 5'd1 : '0;
          hik_nxt = (est == maxk_r) ? maxk_r : est + 5'd1;
          bestc_nxt = '1;
          kc_nxt  = (est != '0) ? est - 5'd1 : '0;
          best_nxt = est;
          bestc_nxt = {1'b0, {(CostW-1){1'b1}}};
        end else begin
          if (cost < bestc_r) begin
            bestc_nxt = cost;
            best_nxt  = kc_r;
          end
          if (kc_r == hik_r) begin
            state_nxt = ST_OUT;
          end else begin
            kc_nxt = kc_r + 5'd1;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          chosen_nxt    = best_r;
          cnt_nxt       = '0;
          out_valid_nxt = 1'b1;
          out_nxt.kind  = KindAnalysis;
          out_nxt.param = best_r;
          out_nxt.zeros = '0;
          out_nxt.rem   = '0;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
    // Arm the window setup on the way into the compare loop.
    if (state_r == ST_DIV && dcnt_r == '0) begin
      bestc_nxt = '1;
      kc_nxt    = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      cnt_r       <= '0;
      chosen_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chosen_r    <= chosen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    maxk_r  <= maxk_nxt;
    prod_r  <= prod_nxt;
    t_r     <= t_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    found_r <= found_nxt;
    msb_r   <= msb_nxt;
    kc_r    <= kc_nxt;
    hik_r   <= hik_nxt;
    best_r  <= best_nxt;
    bestc_r <= bestc_nxt;
    out_r   <= out_nxt;
  end

  for (genvar k = 0; k < NumShifts; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (!rst_n || clr_en) begin
        sums_r[k] <= '0;
      end else if (acc_en) begin
        sums_r[k] <= sums_r[k] + SumW'(q_item.u >> k);
      end
    end
  end

  a_pop_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_RUN)
    else $error("queue popped outside run state");

  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && dcnt_r == '0) |=> state_r == ST_CMP)
    else $error("divider did not hand over to compare");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_en |=> (sums_r[0] == '0 && cnt_r == '0 && out_valid_r))
    else $error("partition state not cleared after header");

endmodule

FILE: hw/rtl/rice_parameter_select_encode.sv
// Path (queue empty, output free): an encode codeword is registered in the queue
// entry, then the output register; a closing analysis header passes two multiply
// steps, 49 divider steps, a window setup and two or three compares, or skips them
// when the sum or count is 0. Throughput: one item per cycle between closes while
// output accepts; a close holds the back end; two-entry queue fills, input stalls.
// Reset: rst_n synchronous active low clears sums, count, parameter, queue.
module rice_parameter_select_encode (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // wide_param_field
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // residual
  input  logic        in_tuser,      // kind
  input  logic        in_tlast,      // last_of_partition
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,     // rice_param, unary_zeros, remainder, zero pad
  output logic        out_tuser      // result_kind
);
  import rpse_pkg::*;

  logic         wide_r;
  logic         q_valid, q_pop;
  rpse_item_t   q_item;
  rpse_result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
    end else if (cfg_wr_en) begin
      wide_r <= cfg_wr_data;
    end
  end

  rpse_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_kind     (in_tuser),
    .in_residual (in_tdata),
    .in_last     (in_tlast),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item)
  );

  rpse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wide       (wide_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {5'd0, res.rem, res.zeros, res.param};

endmodule
